FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL. Each macro expects a clock named clk
// in the scope of use; WFF_ASSERT also needs an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising edge, with reset masking the check.
`define WFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks an implication on every rising edge, including during reset.
`define WFF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/wff_pkg.sv
// ----------------------------------------------------------------------------
// wff_pkg
// Shared types and codes for the window flatten and fill block.
// ----------------------------------------------------------------------------
package wff_pkg;

  // Command codes carried in the input beat.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_FLATTEN = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // Status codes carried in the result beat.
  localparam logic [1:0] ST_INTERIOR = 2'd0;
  localparam logic [1:0] ST_CLIP_LO  = 2'd1;
  localparam logic [1:0] ST_CLIP_HI  = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_HALF_WINDOW   = 1'b0;
  localparam logic REG_SIGNAL_LENGTH = 1'b1;

  localparam int HW_BITS  = 15;
  localparam int LEN_BITS = 17;
  localparam logic [HW_BITS-1:0]  HALF_WINDOW_RST   = 15'd51;
  localparam logic [LEN_BITS-1:0] SIGNAL_LENGTH_RST = 17'd65536;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        position;
    logic signed [31:0] sample_in;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] sample_out;
    logic [15:0]        fill_low;
    logic [15:0]        fill_high;
  } out_t;

endpackage

FILE: hdl/wff_ram.sv
// ----------------------------------------------------------------------------
// wff_ram
// Single-port sample memory with a registered read. One access per cycle:
// a write, or a read whose data appears in the following cycle.
// ----------------------------------------------------------------------------
module wff_ram #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0] wdata,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
  logic [DATA_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/window_flatten_fill.sv
// ----------------------------------------------------------------------------
// window_flatten_fill
// Sample row store with load, read and window-flatten commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until its single result beat, which is shown for one cycle with out_valid
// and must be captured then, as nothing holds it. All work goes through one
// single-port memory, one access per cycle, and that port sets the timing: a
// load writes one entry, a read fetches one, and a flatten reads one end
// sample (both in the interior case) and then writes each fill entry, up to
// twice half_window of them. The store has no reset; reading an entry that was
// never loaded gives an arbitrary value.
module window_flatten_fill #(
  parameter int DEPTH       = 65536,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  wff_pkg::in_t                   in_data,
  output logic                           out_valid,
  output wff_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wff_pkg::LEN_BITS-1:0]   cfg_wdata
);

`include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int IW = wff_pkg::LEN_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_READ, S_END1, S_END2, S_FILL
  } state_t;

  function automatic logic [31:0] to_out(input logic signed [SB-1:0] v);
    return 32'(v);
  endfunction

  // Configuration registers.
  logic [wff_pkg::HW_BITS-1:0] half_window_r;
  logic [IW-1:0]               signal_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_window_r   <= wff_pkg::HALF_WINDOW_RST;
      signal_length_r <= wff_pkg::SIGNAL_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wff_pkg::REG_HALF_WINDOW:   half_window_r   <= cfg_wdata[wff_pkg::HW_BITS-1:0];
        wff_pkg::REG_SIGNAL_LENGTH: signal_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective row length, clamped to one and to the store depth.
  logic [IW-1:0] len;
  always_comb begin
    if (signal_length_r == '0) begin
      len = IW'(1);
    end else if (32'(signal_length_r) > 32'(DEPTH)) begin
      len = IW'(DEPTH);
    end else begin
      len = signal_length_r;
    end
  end

  state_t                 state_r, state_nxt;
  logic [1:0]             cmd_r, cmd_nxt;
  logic [15:0]            pos_r, pos_nxt;
  logic signed [SB-1:0]   samp_r, samp_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [IW-1:0]          fill_lo_r, fill_lo_nxt;
  logic [IW-1:0]          fill_idx_r, fill_idx_nxt;
  logic [IW-1:0]          fill_end_r, fill_end_nxt;
  logic signed [SB-1:0]   end_a_r, end_a_nxt;
  logic signed [SB-1:0]   fill_val_r, fill_val_nxt;
  logic                   out_valid_r, out_valid_nxt;
  wff_pkg::out_t          out_data_r, out_data_nxt;

  logic                   ram_en, ram_we;
  logic [AW-1:0]          ram_addr;
  logic [SB-1:0]          ram_wdata, ram_rdata;

  // Window ends for the flatten command.
  logic signed [IW:0]     lo_s;
  logic [IW:0]            hi_w;
  logic                   low_out, high_out, lo_past;
  logic                   pos_ok;
  logic signed [SB:0]     pair_sum;

  always_comb begin
    lo_s     = $signed({2'b00, pos_r}) - $signed({3'b000, half_window_r});
    hi_w     = {2'b00, pos_r} + {3'b000, half_window_r};
    low_out  = lo_s[IW];
    high_out = hi_w >= {1'b0, len};
    lo_past  = !low_out && (lo_s[IW-1:0] >= len);
    pos_ok   = 32'(pos_r) < 32'(DEPTH);
    pair_sum = {end_a_r[SB-1], end_a_r} + {ram_rdata[SB-1], ram_rdata};
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    samp_nxt      = samp_r;
    status_nxt    = status_r;
    fill_lo_nxt   = fill_lo_r;
    fill_idx_nxt  = fill_idx_r;
    fill_end_nxt  = fill_end_r;
    end_a_nxt     = end_a_r;
    fill_val_nxt  = fill_val_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = AW'(pos_r);
    ram_wdata     = fill_val_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_data.cmd;
          pos_nxt   = in_data.position;
          samp_nxt  = SB'($signed(in_data.sample_in));
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        case (cmd_r)
          wff_pkg::CMD_LOAD: begin
            ram_en    = pos_ok;
            ram_we    = 1'b1;
            ram_wdata = samp_r;
            out_valid_nxt = 1'b1;
            out_data_nxt.sample_out = to_out(samp_r);
            state_nxt = S_IDLE;
          end
          wff_pkg::CMD_READ: begin
            if (pos_ok) begin
              ram_en    = 1'b1;
              state_nxt = S_READ;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          wff_pkg::CMD_FLATTEN: begin
            if ((low_out && high_out) || (high_out && lo_past)) begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = wff_pkg::ST_OUTSIDE;
              state_nxt           = S_IDLE;
            end else begin
              ram_en = 1'b1;
              if (low_out) begin
                status_nxt   = wff_pkg::ST_CLIP_LO;
                fill_lo_nxt  = '0;
                fill_end_nxt = hi_w[IW-1:0];
                ram_addr     = AW'(hi_w[IW-1:0]);
              end else if (high_out) begin
                status_nxt   = wff_pkg::ST_CLIP_HI;
                fill_lo_nxt  = lo_s[IW-1:0];
                fill_end_nxt = len - IW'(1);
                ram_addr     = AW'(lo_s[IW-1:0]);
              end else begin
                status_nxt   = wff_pkg::ST_INTERIOR;
                fill_lo_nxt  = lo_s[IW-1:0];
                fill_end_nxt = hi_w[IW-1:0];
                ram_addr     = AW'(lo_s[IW-1:0]);
              end
              fill_idx_nxt = fill_lo_nxt;
              state_nxt    = S_END1;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      S_READ: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.sample_out = to_out(ram_rdata);
        state_nxt               = S_IDLE;
      end

      S_END1: begin
        if (status_r == wff_pkg::ST_INTERIOR) begin
          // The low end is in; fetch the high end for the average.
          end_a_nxt = ram_rdata;
          ram_en    = 1'b1;
          ram_addr  = AW'(fill_end_r);
          state_nxt = S_END2;
        end else begin
          fill_val_nxt = ram_rdata;
          state_nxt    = S_FILL;
        end
      end

      S_END2: begin
        fill_val_nxt = pair_sum[SB:1];
        state_nxt    = S_FILL;
      end

      S_FILL: begin
        if (fill_idx_r < fill_end_r) begin
          ram_en       = 1'b1;
          ram_we       = 1'b1;
          ram_addr     = AW'(fill_idx_r);
          fill_idx_nxt = fill_idx_r + IW'(1);
        end else begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.sample_out = to_out(fill_val_r);
          out_data_nxt.fill_low   = fill_lo_r[15:0];
          out_data_nxt.fill_high  = fill_end_r[15:0];
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    samp_r     <= samp_nxt;
    status_r   <= status_nxt;
    fill_lo_r  <= fill_lo_nxt;
    fill_idx_r <= fill_idx_nxt;
    fill_end_r <= fill_end_nxt;
    end_a_r    <= end_a_nxt;
    fill_val_r <= fill_val_nxt;
    out_data_r <= out_data_nxt;
  end

  wff_ram #(
    .ADDR_BITS (AW),
    .DATA_BITS (SB)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WFF_ASSERT(a_one_beat, out_valid |=> !out_valid, "result beat lasted more than one cycle")
  `WFF_ASSERT(a_take_busy, (start && !busy) |=> busy, "command taken but block not busy")
  `WFF_ASSERT(a_beat_idle, out_valid |-> !busy, "result beat shown while still busy")
  `WFF_ASSERT(a_outside_empty, (out_valid && out_data.status == wff_pkg::ST_OUTSIDE) |-> (out_data.fill_low == 16'd0 && out_data.fill_high == 16'd0), "outside window reported a fill range")

endmodule
